// File: hdl/stt_pkg.sv
// Shared types and constants of the timer slot table.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int COUNT_W       = 15;
  localparam int KIND_W        = 2;
  localparam int SLOT_W        = 4;
  localparam int RESULT_LIMIT  = 16;
  localparam int RES_CNT_W     = 5;
  localparam int MAX_SLOTS_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;
    logic tick_start;
    logic step;
    logic flush;
  } stt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic at_end;
    logic hit_emit;
    logic pend_v;
    logic out_busy;
  } stt_sts_t;

endpackage

`default_nettype wire

// File: hdl/stt_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [stt_pkg::COUNT_W-1:0]  start_ticks;
  logic [stt_pkg::COUNT_W-1:0]  reload_ticks;

  modport source (output valid, output mode, output start_ticks, output reload_ticks,
                  input ready);
  modport sink (input valid, input mode, input start_ticks, input reload_ticks,
                output ready);
endinterface

interface stt_out_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::KIND_W-1:0]  kind;
  logic [stt_pkg::SLOT_W-1:0]  slot;
  logic                        last;

  modport source (output valid, output kind, output slot, output last, input ready);
  modport sink (input valid, input kind, input slot, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/stt_ctrl.sv
// Controller state machine: accepts words and sequences the slot walk.
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_ready,
  input  wire stt_pkg::stt_sts_t sts,
  output stt_pkg::stt_cmd_t      cmd,
  output stt_pkg::state_t        state
);

  stt_pkg::state_t state_r, state_nxt;
  logic            accept;
  logic            stall;

  assign in_ready = (state_r == stt_pkg::ST_IDLE) && !sts.out_busy;
  assign accept   = in_valid && in_ready;
  // A second expiry can only be taken once the held one has moved out.
  assign stall    = sts.hit_emit && sts.pend_v && sts.out_busy;
  assign state    = state_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stt_pkg::ST_IDLE: begin
        if (accept && (in_mode == stt_pkg::MODE_TICK) && !sts.empty) begin
          state_nxt = stt_pkg::ST_WALK;
        end
      end
      stt_pkg::ST_WALK: begin
        if (!stall && sts.at_end) begin
          state_nxt = stt_pkg::ST_FLUSH;
        end
      end
      stt_pkg::ST_FLUSH: begin
        if (!sts.pend_v || !sts.out_busy) begin
          state_nxt = stt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      stt_pkg::ST_IDLE: begin
        cmd.add        = accept && (in_mode == stt_pkg::MODE_ADD);
        cmd.tick_start = accept && (in_mode == stt_pkg::MODE_TICK);
      end
      stt_pkg::ST_WALK: begin
        cmd.step = !stall;
      end
      stt_pkg::ST_FLUSH: begin
        cmd.flush = sts.pend_v && !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stt_dp.sv
// Datapath: slot memory, occupancy count, walk index, held expiry and output register.
`timescale 1ns / 1ps
`default_nettype none

module stt_dp #(
  parameter int MAX_SLOTS = stt_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stt_pkg::stt_cmd_t           cmd,
  output stt_pkg::stt_sts_t                sts,
  input  wire logic [stt_pkg::COUNT_W-1:0] start_ticks,
  input  wire logic [stt_pkg::COUNT_W-1:0] reload_ticks,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [stt_pkg::KIND_W-1:0]       out_kind,
  output logic [stt_pkg::SLOT_W-1:0]       out_slot,
  output logic                             out_last,
  output logic [$clog2(MAX_SLOTS+1)-1:0]   slots_used
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int DW = 2 * stt_pkg::COUNT_W;

  // Each word holds {reload count, remaining count}.
  logic [DW-1:0] mem [MAX_SLOTS];
  logic [DW-1:0] rd_data_r;

  logic [IW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  logic [CW-1:0]                 slots_used_r, slots_used_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [stt_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [IW-1:0]                 pend_slot_r, pend_slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [stt_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [stt_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [stt_pkg::COUNT_W-1:0] rem_cur, rel_cur;
  logic                        full, hit, hit_emit, out_busy;

  assign rem_cur  = rd_data_r[stt_pkg::COUNT_W-1:0];
  assign rel_cur  = rd_data_r[DW-1:stt_pkg::COUNT_W];
  assign full     = (slots_used_r == CW'(MAX_SLOTS));
  assign hit      = (rem_cur == stt_pkg::COUNT_W'(1));
  assign hit_emit = hit && (res_cnt_r != stt_pkg::RES_CNT_W'(stt_pkg::RESULT_LIMIT));
  assign out_busy = out_valid_r && !out_ready;

  assign sts.empty    = (slots_used_r == '0);
  assign sts.at_end   = ((CW+1)'(idx_r) + (CW+1)'(1)) == (CW+1)'(slots_used_r);
  assign sts.hit_emit = hit_emit;
  assign sts.pend_v   = pend_v_r;
  assign sts.out_busy = out_busy;

  // The read runs one slot ahead of the slot being updated, so the walk
  // takes one slot per cycle unless the output is blocked.
  always_comb begin
    if (cmd.tick_start) begin
      rd_addr = '0;
    end else if (cmd.step) begin
      rd_addr = idx_r + IW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {rel_cur, rem_cur - stt_pkg::COUNT_W'(1)};
    if (cmd.add) begin
      wr_en   = !full;
      wr_addr = slots_used_r[IW-1:0];
      wr_data = {reload_ticks, start_ticks};
    end else if (cmd.step) begin
      wr_en = (rem_cur != '0);
      if (hit) begin
        wr_data = {rel_cur, rel_cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    slots_used_nxt = slots_used_r;
    idx_nxt        = idx_r;
    res_cnt_nxt    = res_cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;

    if (cmd.add) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (full) begin
        out_kind_nxt = stt_pkg::KIND_FULL;
        out_slot_nxt = '0;
      end else begin
        out_kind_nxt   = stt_pkg::KIND_ACCEPT;
        out_slot_nxt   = stt_pkg::SLOT_W'(slots_used_r);
        slots_used_nxt = slots_used_r + CW'(1);
      end
    end

    if (cmd.tick_start) begin
      idx_nxt     = '0;
      res_cnt_nxt = '0;
      pend_v_nxt  = 1'b0;
    end

    if (cmd.step) begin
      idx_nxt = idx_r + IW'(1);
      if (hit_emit) begin
        // The held expiry is not the final one: send it with last low.
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stt_pkg::KIND_EXPIRED;
          out_slot_nxt  = stt_pkg::SLOT_W'(pend_slot_r);
          out_last_nxt  = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_slot_nxt = idx_r;
        res_cnt_nxt   = res_cnt_r + stt_pkg::RES_CNT_W'(1);
      end
    end

    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = stt_pkg::KIND_EXPIRED;
      out_slot_nxt  = stt_pkg::SLOT_W'(pend_slot_r);
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      slots_used_r <= slots_used_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    res_cnt_r   <= res_cnt_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_slot   = out_slot_r;
  assign out_last   = out_last_r;
  assign slots_used = slots_used_r;

endmodule

`default_nettype wire

// File: hdl/multi_slot_software_timer_table_core.sv
// Top level of the timer slot table: controller, datapath and channel hookup.
`timescale 1ns / 1ps
`default_nettype none

// Timer slot table. An add word (mode 1) claims the next free slot, loads its
// start and reload counts and answers with one word: the slot number, or a
// table-full rejection once MAX_SLOTS slots are taken.
// A tick word (mode 0) walks the occupied slots from slot 0 up, one slot per
// cycle unless a held expiry waits on a stalled output, through the slot
// memory, which reads the next slot while the current one is written back.
// It decrements nonzero counts and reloads those that reach zero; each
// expiry, up to RESULT_LIMIT per tick, yields one word, the final one of the
// tick marked last. Slots are never freed, and a slot whose count is zero
// stays idle. A new word is taken once the previous one is fully worked off
// and its last result has left the output register, or leaves it in the same
// cycle.
module multi_slot_software_timer_table_core #(
  parameter int MAX_SLOTS = stt_pkg::MAX_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  stt_pkg::stt_cmd_t cmd;
  stt_pkg::stt_sts_t sts;
  stt_pkg::state_t   state;
  logic [CW-1:0]     slots_used;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  stt_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .start_ticks  (in_ch.start_ticks),
    .reload_ticks (in_ch.reload_ticks),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_slot     (out_ch.slot),
    .out_last     (out_ch.last),
    .slots_used   (slots_used)
  );

  // An add result is always the only word of its item.
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind != stt_pkg::KIND_EXPIRED) |-> out_ch.last)
    else $error("add result without last");

  // An expiry held back for the last flag only exists during a tick.
  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend_v |-> (state != stt_pkg::ST_IDLE))
    else $error("held expiry outside a tick");

  // The occupancy count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used <= CW'(MAX_SLOTS))
    else $error("slot count beyond table size");

  // A finished tick leaves nothing held back.
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state == stt_pkg::ST_FLUSH) && !sts.out_busy |=> !sts.pend_v)
    else $error("held expiry not sent at end of tick");

endmodule

`default_nettype wire
